@@ rtl/core/depth_pixel_to_world_point_core_defines.svh @@
// Assertion macros for the depth pixel to world point core.
`ifndef DEPTH_PIXEL_TO_WORLD_POINT_CORE_DEFINES_SVH
`define DEPTH_PIXEL_TO_WORLD_POINT_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk outside reset.
`define DPW_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define DPW_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

@@ rtl/core/dpw_pkg.sv @@
// Shared types and constants of the depth pixel to world point core.
package dpw_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 63;

  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  // Register indexes
  localparam cfg_idx_t REG_ROT0  = 3'd0;
  localparam cfg_idx_t REG_ROT1  = 3'd1;
  localparam cfg_idx_t REG_ROT2  = 3'd2;
  localparam cfg_idx_t REG_TRANS = 3'd3;
  localparam cfg_idx_t REG_PP    = 3'd4;
  localparam cfg_idx_t REG_IFOC  = 3'd5;
  localparam cfg_idx_t REG_IDS   = 3'd6;

  // Reset values
  localparam logic [53:0] ROT0_RST  = 54'd65536;
  localparam logic [53:0] ROT1_RST  = 54'd17179869184;
  localparam logic [53:0] ROT2_RST  = 54'd4503599627370496;
  localparam logic [62:0] TRANS_RST = 63'd0;
  localparam logic [31:0] PP_RST    = 32'd265819224;
  localparam logic [47:0] IFOC_RST  = 48'd542340316804;
  localparam logic [31:0] IDS_RST   = 32'd4294967;

  typedef logic [53:0] rot_row_t;
  typedef logic [23:0] color_t;

endpackage

@@ rtl/core/depth_pixel_to_world_point_core.sv @@
// Top level of the depth pixel to world point core.
// Back-projects one RGB-D pixel per item through a pinhole model
// (z = depth * inverse scale, x = (u-cx)*z/fx, y = (v-cy)*z/fy), then applies
// the configured rotation and translation and emits a saturated Q15.16 world
// point with the pixel color. A pixel with zero depth, or outside the
// MAX_COLUMNS x MAX_ROWS frame, produces no result. Throughput is one item
// per clock while the output is not stalled; the pipe has seven register stages
// in the multiply chain (depth scale, focal scale, z product, rotation). Each stage
// advances on its own when the next one is empty or moving, so bubbles close
// up and a stalled output holds the pipe without loss. Register writes must
// happen only while the pipe is empty.
module depth_pixel_to_world_point_core #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  dpw_pkg::cfg_idx_t   cfg_index,
  input  dpw_pkg::cfg_data_t  cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [9:0]          column,
  input  logic [9:0]          row,
  input  logic [15:0]         depth_raw,
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  world_x,
  output logic signed [31:0]  world_y,
  output logic signed [31:0]  world_z,
  output logic [7:0]          point_red,
  output logic [7:0]          point_green,
  output logic [7:0]          point_blue
);
  import dpw_pkg::*;
  `include "depth_pixel_to_world_point_core_defines.svh"

  localparam int NSTG = 7;

  // ---------------- configuration registers ----------------
  rot_row_t     rot [3];
  logic [62:0]  trans;
  logic [31:0]  pp;
  logic [47:0]  ifoc;
  logic [31:0]  ids;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot[0] <= ROT0_RST;
      rot[1] <= ROT1_RST;
      rot[2] <= ROT2_RST;
      trans  <= TRANS_RST;
      pp     <= PP_RST;
      ifoc   <= IFOC_RST;
      ids    <= IDS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROT0:  rot[0] <= cfg_data[53:0];
        REG_ROT1:  rot[1] <= cfg_data[53:0];
        REG_ROT2:  rot[2] <= cfg_data[53:0];
        REG_TRANS: trans  <= cfg_data;
        REG_PP:    pp     <= cfg_data[31:0];
        REG_IFOC:  ifoc   <= cfg_data[47:0];
        REG_IDS:   ids    <= cfg_data[31:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // ---------------- flow control ----------------
  // vld[k] marks stage k full; en[k] lets stage k load.
  logic [NSTG:1] vld;
  logic [NSTG:1] en;

  always_comb begin
    en[NSTG] = !vld[NSTG] || out_ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready = en[1];

  logic in_take;
  logic in_frame;
  assign in_take  = in_valid && in_ready;
  assign in_frame = ({22'd0, column} < MAX_COLUMNS) && ({22'd0, row} < MAX_ROWS);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= in_take && (depth_raw != 16'd0) && in_frame;
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // ---------------- stage 1: depth product, pixel offsets ----------------
  logic [47:0]        s1_zp;
  logic signed [17:0] s1_du, s1_dv;
  color_t             s1_col;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_zp  <= {32'd0, depth_raw} * {16'd0, ids};
      s1_du  <= $signed({4'd0, column, 4'd0}) - $signed({2'd0, pp[15:0]});
      s1_dv  <= $signed({4'd0, row, 4'd0}) - $signed({2'd0, pp[31:16]});
      s1_col <= {red, green, blue};
    end
  end

  // ---------------- stage 2: z, focal products ----------------
  logic [47:0]        s1_zr;
  logic [31:0]        s2_z;
  logic signed [42:0] s2_nxp, s2_nyp;
  color_t             s2_col;

  assign s1_zr = s1_zp + 48'h8000;  // no carry out: product < 2^48 - 2^32

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_z   <= s1_zr[47:16];
      s2_nxp <= 43'(s1_du * $signed({1'b0, ifoc[23:0]}));
      s2_nyp <= 43'(s1_dv * $signed({1'b0, ifoc[47:24]}));
      s2_col <= s1_col;
    end
  end

  // ---------------- stage 3: round normalized coordinates ----------------
  logic signed [42:0] s2_nxr, s2_nyr;
  logic signed [29:0] s3_nx, s3_ny;
  logic [31:0]        s3_z;
  color_t             s3_col;

  assign s2_nxr = (s2_nxp + 43'sd2048) >>> 12;
  assign s2_nyr = (s2_nyp + 43'sd2048) >>> 12;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_nx  <= s2_nxr[29:0];
      s3_ny  <= s2_nyr[29:0];
      s3_z   <= s2_z;
      s3_col <= s2_col;
    end
  end

  // ---------------- stage 4: scale by z ----------------
  logic signed [62:0] s4_xp, s4_yp;
  logic [31:0]        s4_z;
  color_t             s4_col;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_xp  <= 63'(s3_nx * $signed({1'b0, s3_z}));
      s4_yp  <= 63'(s3_ny * $signed({1'b0, s3_z}));
      s4_z   <= s3_z;
      s4_col <= s3_col;
    end
  end

  // ---------------- stage 5: camera point ----------------
  logic signed [62:0] s4_xr, s4_yr;
  logic signed [45:0] s5_p [3];
  color_t             s5_col;

  assign s4_xr = (s4_xp + 63'sd32768) >>> 16;
  assign s4_yr = (s4_yp + 63'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_p[0] <= s4_xr[45:0];
      s5_p[1] <= s4_yr[45:0];
      s5_p[2] <= $signed({14'd0, s4_z});
      s5_col  <= s4_col;
    end
  end

  // ---------------- stage 6: rotation products ----------------
  logic signed [63:0] s6_prod [3][3];
  color_t             s6_col;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s6_prod[i][j] <= 64'($signed(rot[i][18*j +: 18]) * s5_p[j]);
        end
      end
      s6_col <= s5_col;
    end
  end

  // ---------------- stage 7: round, sum, translate, saturate ----------------
  logic signed [63:0] s6_term [3][3];
  logic signed [49:0] s6_sum  [3];
  logic signed [31:0] s6_sat  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s6_term[i][j] = (s6_prod[i][j] + 64'sd32768) >>> 16;
      end
      s6_sum[i] = 50'($signed(trans[21*i +: 21]))
                + s6_term[i][0][49:0] + s6_term[i][1][49:0] + s6_term[i][2][49:0];
      if (s6_sum[i] > 50'sd2147483647) begin
        s6_sat[i] = 32'sh7fffffff;
      end else if (s6_sum[i] < -50'sd2147483648) begin
        s6_sat[i] = 32'sh80000000;
      end else begin
        s6_sat[i] = s6_sum[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      world_x     <= s6_sat[0];
      world_y     <= s6_sat[1];
      world_z     <= s6_sat[2];
      point_red   <= s6_col[23:16];
      point_green <= s6_col[15:8];
      point_blue  <= s6_col[7:0];
    end
  end

  assign out_valid = vld[NSTG];

  // ---------------- assertions ----------------
  `DPW_ASSERT_NEXT(a_zero_depth_dropped, in_take && depth_raw == 16'd0, !vld[1], "zero depth entered pipe")
  `DPW_ASSERT_NOW(a_full_pipe_blocks, (&vld) && !out_ready, !in_ready, "input taken into full stalled pipe")
  `DPW_ASSERT_NEXT(a_stage1_holds, vld[1] && !en[1], vld[1] && $stable(s1_zp), "stage 1 item lost in stall")

endmodule

@@ tb/tb_depth_pixel_to_world_point_core.sv @@
// Testbench for the depth pixel to world point core: predicted points vs. DUT output.
`timescale 1ns / 100ps

module tb_depth_pixel_to_world_point_core;
  import dpw_pkg::*;

  // Predicted world point with its color
  typedef struct {
    logic signed [31:0] wx, wy, wz;
    logic [7:0]         r, g, b;
  } world_point_t;

  localparam int PIPE_LAT     = 7;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_OFF_LEN = 300;

  logic               clk, rst;
  logic               cfg_we;
  cfg_idx_t           cfg_index;
  cfg_data_t          cfg_data;
  logic               in_valid, in_ready;
  logic [9:0]         column, row;
  logic [15:0]        depth_raw;
  logic [7:0]         red, green, blue;
  logic               out_valid, out_ready;
  logic signed [31:0] world_x, world_y, world_z;
  logic [7:0]         point_red, point_green, point_blue;

  // Shadow copy of the register file
  logic [53:0] rot_row [3];
  logic [62:0] trans_sh;
  logic [31:0] pp_sh;
  logic [47:0] ifoc_sh;
  logic [31:0] ids_sh;

  world_point_t expected_points[$];
  int           mismatch_cnt = 0;
  int           cycle_cnt = 0;
  int           hold_off_req = 0;     // bumped by the test to request a long stall
  int           hold_off_ack = 0;     // last request seen by the receiver
  int           hold_off_cycles = 0;  // forced long receiver stall
  int           burst_left;

  depth_pixel_to_world_point_core i_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .column, .row, .depth_raw, .red, .green, .blue,
    .out_valid, .out_ready, .world_x, .world_y, .world_z,
    .point_red, .point_green, .point_blue
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // round half up then floor, arithmetic shift
  function automatic longint rnd_shift(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint rot_coef(int i, int j);
    logic [17:0] c;
    c = rot_row[i][18*j +: 18];
    return longint'($signed(c));
  endfunction

  // Pinhole back-projection plus rigid transform, bit-exact fixed point
  function automatic world_point_t project_pixel(logic [9:0] u, logic [9:0] v,
                                                 logic [15:0] d, logic [7:0] r,
                                                 logic [7:0] g, logic [7:0] b);
    world_point_t pt;
    longint z, du, dv, nx, ny, acc;
    longint p [3];
    logic [20:0] tcomp;
    logic [31:0] sat;
    z  = (longint'(d) * longint'(ids_sh) + 64'h8000) >>> 16;
    du = longint'({u, 4'b0}) - longint'(pp_sh[15:0]);
    dv = longint'({v, 4'b0}) - longint'(pp_sh[31:16]);
    nx = rnd_shift(du * longint'(ifoc_sh[23:0]), 12);
    ny = rnd_shift(dv * longint'(ifoc_sh[47:24]), 12);
    p[0] = rnd_shift(nx * z, 16);
    p[1] = rnd_shift(ny * z, 16);
    p[2] = z;
    for (int i = 0; i < 3; i++) begin
      tcomp = trans_sh[21*i +: 21];
      acc = longint'($signed(tcomp));
      for (int j = 0; j < 3; j++) acc += rnd_shift(rot_coef(i, j) * p[j], 16);
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      sat = acc[31:0];
      if (i == 0) pt.wx = sat;
      else if (i == 1) pt.wy = sat;
      else pt.wz = sat;
    end
    pt.r = r; pt.g = g; pt.b = b;
    return pt;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("t=%0t %s: got %0h expected %0h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // Receiver: own stall pattern, plus the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off_ack != hold_off_req) begin
      hold_off_ack    <= hold_off_req;
      hold_off_cycles <= HOLD_OFF_LEN;
      out_ready       <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      out_ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      case (cycle_cnt[10:9])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= ($urandom_range(3) != 0);
        default: out_ready <= ($urandom_range(1) == 0);
      endcase
    end
  end

  // Result checker
  always @(posedge clk) begin
    world_point_t exp_pt;
    if (!rst && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected point", world_x, 32'd0);
      end else begin
        exp_pt = expected_points.pop_front();
        if (world_x !== exp_pt.wx) report_mismatch("world_x", world_x, exp_pt.wx);
        if (world_y !== exp_pt.wy) report_mismatch("world_y", world_y, exp_pt.wy);
        if (world_z !== exp_pt.wz) report_mismatch("world_z", world_z, exp_pt.wz);
        if (point_red !== exp_pt.r)
          report_mismatch("point_red", 32'(point_red), 32'(exp_pt.r));
        if (point_green !== exp_pt.g)
          report_mismatch("point_green", 32'(point_green), 32'(exp_pt.g));
        if (point_blue !== exp_pt.b)
          report_mismatch("point_blue", 32'(point_blue), 32'(exp_pt.b));
      end
    end
  end

  // Sends one pixel; bursts of random length separated by random gaps
  task automatic send_pixel(logic [9:0] u, logic [9:0] v, logic [15:0] d,
                            logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid  <= 1'b1;
    column    <= u;
    row       <= v;
    depth_raw <= d;
    red       <= r;
    green     <= g;
    blue      <= b;
    if (d != 0)
      expected_points.insert(expected_points.size(), project_pixel(u, v, d, r, g, b));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_pixel();
    logic [15:0] d;
    case ($urandom_range(9))
      0: d = 16'd0;
      1: d = 16'hffff;
      2: d = 16'($urandom_range(1, 15));
      default: d = 16'($urandom);
    endcase
    send_pixel(10'($urandom), 10'($urandom), d, 8'($urandom), 8'($urandom),
               8'($urandom));
  endtask

  // Release valid, wait for the pipe to drain, then the latency margin
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_ROT0:  rot_row[0] = val[53:0];
      REG_ROT1:  rot_row[1] = val[53:0];
      REG_ROT2:  rot_row[2] = val[53:0];
      REG_TRANS: trans_sh   = val[62:0];
      REG_PP:    pp_sh      = val[31:0];
      REG_IFOC:  ifoc_sh    = val[47:0];
      REG_IDS:   ids_sh     = val[31:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic cfg_data_t rand_data();
    return cfg_data_t'({$urandom, $urandom});
  endfunction

  // Directed: field extremes, zero depth, corners of the frame
  task automatic test_directed();
    send_pixel(10'd0, 10'd0, 16'd1, 8'h00, 8'h00, 8'h00);
    send_pixel(10'd1023, 10'd1023, 16'hffff, 8'hff, 8'hff, 8'hff);
    send_pixel(10'd0, 10'd1023, 16'd1000, 8'haa, 8'h55, 8'h0f);
    send_pixel(10'd1023, 10'd0, 16'd1000, 8'h55, 8'haa, 8'hf0);
    send_pixel(10'd325, 10'd253, 16'd0, 8'h12, 8'h34, 8'h56);  // zero depth
    send_pixel(10'd326, 10'd254, 16'd0, 8'h01, 8'h02, 8'h03);
    send_pixel(10'd325, 10'd253, 16'd2000, 8'h01, 8'h02, 8'h03);
    send_pixel(10'd512, 10'd512, 16'h8000, 8'h80, 8'h80, 8'h80);
    send_pixel(10'h2aa, 10'h155, 16'haaaa, 8'h7f, 8'h7f, 8'h7f);
    send_pixel(10'h155, 10'h2aa, 16'h5555, 8'h80, 8'h01, 8'hfe);
    drain();
  endtask

  task automatic test_random(int n);
    repeat (n) send_random_pixel();
    drain();
  endtask

  // Extreme settings: full-scale coefficients and offsets drive saturation, then zeroed coefficients
  task automatic test_config_extremes();
    write_reg(REG_ROT0, {9{7'h7f}} & 63'h3f_ffff_ffff_ffff);
    write_reg(REG_ROT1, cfg_data_t'({18'h20000, 18'h20000, 18'h20000}));
    write_reg(REG_ROT2, cfg_data_t'({18'h1ffff, 18'h20000, 18'h1ffff}));
    write_reg(REG_TRANS, {21'h0fffff, 21'h100000, 21'h1fffff});
    write_reg(REG_PP, cfg_data_t'(32'hffff_0000));
    write_reg(REG_IFOC, cfg_data_t'(48'hffffff_ffffff));
    write_reg(REG_IDS, cfg_data_t'(32'hffff_ffff));
    test_random(120);
    write_reg(REG_ROT0, '0);
    write_reg(REG_ROT1, '0);
    write_reg(REG_ROT2, '0);
    write_reg(REG_TRANS, '0);
    write_reg(REG_PP, cfg_data_t'(32'h0000_ffff));
    write_reg(REG_IFOC, '0);
    write_reg(REG_IDS, '0);
    test_random(60);
  endtask

  // Random settings in several phases; also an unknown register index
  task automatic test_config_random();
    for (int ph = 0; ph < 5; ph++) begin
      for (int k = 0; k < 7; k++) write_reg(cfg_idx_t'(k), rand_data());
      write_reg(cfg_idx_t'(7), rand_data());
      test_random(150);
    end
  endtask

  // Receiver holds off while the sender keeps offering pixels
  task automatic test_backpressure();
    hold_off_req++;
    test_random(150);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; column = '0; row = '0; depth_raw = '0;
    red = '0; green = '0; blue = '0;
    burst_left = 0;
    rot_row[0] = ROT0_RST; rot_row[1] = ROT1_RST; rot_row[2] = ROT2_RST;
    trans_sh = TRANS_RST; pp_sh = PP_RST; ifoc_sh = IFOC_RST; ids_sh = IDS_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(300);
    test_backpressure();
    test_config_extremes();
    test_config_random();

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/dpw_pkg.sv
rtl/core/depth_pixel_to_world_point_core.sv
tb/tb_depth_pixel_to_world_point_core.sv
